// ----- design/kmp_occurrence_counter_core_defines.svh -----
// assertion macros for the kmp occurrence counter
// used by the top level; clock i_clk and reset i_rst_n are fixed here
`ifndef KMP_OCCURRENCE_COUNTER_CORE_DEFINES_SVH
`define KMP_OCCURRENCE_COUNTER_CORE_DEFINES_SVH

// same-cycle implication
`define KMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kmp assertion failed");

// next-cycle implication
`define KMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kmp assertion failed");

`endif

// ----- design/kmpoc_pkg.sv -----
// shared types and constants for the kmp occurrence counter
// no dependencies
package kmpoc_pkg;

    localparam int BYTE_W      = 8;
    localparam int OUT_COUNT_W = 16;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic quick;
        logic cmp_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- design/kmp_occurrence_counter_core.sv -----
// channel | handshake          | payload
// in      | i_valid / o_ready  | i_action, i_byte_value, i_first
// out     | o_valid / i_ready  | o_match_here, o_match_count, o_pattern_full
//
// a pattern byte goes straight to the done state when the store is empty or
// full, as does text with an empty pattern; otherwise the compare state
// follows failure links one at a time, set by the single read port of each memory
// reset is synchronous, active low; the memories are not cleared
// a finished result waits in the output register, and the next item is
// taken meanwhile; it stalls only if its own result is ready before that
// top level of the kmp occurrence counter; depends on kmpoc_pkg, kmpoc_ctrl,
// kmpoc_dp and kmp_occurrence_counter_core_defines.svh
`include "kmp_occurrence_counter_core_defines.svh"

module kmp_occurrence_counter_core #(
    parameter int PATTERN_MAX = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_action,
    input  logic [kmpoc_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                                i_first,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_match_here,
    output logic [kmpoc_pkg::OUT_COUNT_W-1:0]   o_match_count,
    output logic                                o_pattern_full
);

    kmpoc_pkg::t_dp_cmd    w_cmd;
    kmpoc_pkg::t_dp_status w_status;

    kmpoc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    kmpoc_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_action       (i_action),
        .i_byte_value   (i_byte_value),
        .i_first        (i_first),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_match_here   (o_match_here),
        .o_match_count  (o_match_count),
        .o_pattern_full (o_pattern_full)
    );

    `KMP_ASSERT_IMP(a_result_kind, o_valid, !(o_match_here && o_pattern_full))
    `KMP_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    `KMP_ASSERT_NXT(a_load_shows_result, w_cmd.load_out, o_valid)

endmodule

// ----- design/kmpoc_ctrl.sv -----
// controller state machine for the kmp occurrence counter
// depends on kmpoc_pkg
module kmpoc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  kmpoc_pkg::t_dp_status  i_status,
    output kmpoc_pkg::t_dp_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.load_out = 1'b0;
        o_ready        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.quick ? ST_DONE : ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
                if (i_status.cmp_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/kmpoc_dp.sv -----
// datapath for the kmp occurrence counter: pattern and failure memories,
// match progress, count and the output register; depends on kmpoc_pkg
module kmpoc_dp #(
    parameter int PATTERN_MAX = 64,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kmpoc_pkg::t_dp_cmd                  i_cmd,
    output kmpoc_pkg::t_dp_status               o_status,
    input  logic                                i_action,
    input  logic [kmpoc_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                                i_first,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_match_here,
    output logic [kmpoc_pkg::OUT_COUNT_W-1:0]   o_match_count,
    output logic                                o_pattern_full
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);

    logic [kmpoc_pkg::BYTE_W-1:0] mem_store [PATTERN_MAX];
    logic [LW-1:0]                mem_fail  [PATTERN_MAX];

    logic [LW-1:0]                r_len, n_len;
    logic [LW-1:0]                r_prog, n_prog;
    logic [LW-1:0]                r_last_fail, n_last_fail;
    logic [LW-1:0]                r_k, n_k;
    logic [COUNT_BITS-1:0]        r_count, n_count;
    logic                         r_hit, n_hit;
    logic                         r_full, n_full;
    logic [kmpoc_pkg::BYTE_W-1:0] r_byte;
    logic                         r_is_text;
    logic [kmpoc_pkg::BYTE_W-1:0] r_store_q;
    logic [LW-1:0]                r_fail_q;

    logic                         r_out_valid;
    logic                         r_out_hit;
    logic [kmpoc_pkg::OUT_COUNT_W-1:0] r_out_count;
    logic                         r_out_full;

    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    logic [kmpoc_pkg::BYTE_W-1:0] w_wbyte;
    logic [LW-1:0]                w_wfail;
    logic [LW-1:0]                w_km1;
    logic [LW-1:0]                w_eff_len;
    logic [LW-1:0]                w_eff_prog;
    logic [LW-1:0]                w_k_fin;
    logic                         w_match;
    logic                         w_last;

    assign w_eff_len  = (!i_action && i_first) ? '0 : r_len;
    assign w_eff_prog = i_first ? '0 : r_prog;
    assign w_match    = (r_store_q == r_byte);
    assign w_last     = w_match || (r_k == '0);
    assign w_k_fin    = w_match ? (r_k + LW'(1)) : '0;
    assign w_km1      = n_k - LW'(1);

    assign o_status.quick    = i_action ? (r_len == '0)
                             : ((w_eff_len == '0) || (w_eff_len >= LW'(PATTERN_MAX)));
    assign o_status.cmp_last = w_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_len       = r_len;
        n_prog      = r_prog;
        n_last_fail = r_last_fail;
        n_k         = r_k;
        n_count     = r_count;
        n_hit       = r_hit;
        n_full      = r_full;
        w_we        = 1'b0;
        w_waddr     = r_len[IW-1:0];
        w_wbyte     = r_byte;
        w_wfail     = w_k_fin;
        if (i_cmd.accept) begin
            n_hit  = 1'b0;
            n_full = 1'b0;
            if (!i_action) begin
                n_len = w_eff_len;
                if (i_first) begin
                    n_prog = '0;
                end
                n_k = r_last_fail;
                if (w_eff_len >= LW'(PATTERN_MAX)) begin
                    n_full = 1'b1;
                end else if (w_eff_len == '0) begin
                    // first byte of a pattern has no prefix to match
                    w_we        = 1'b1;
                    w_waddr     = '0;
                    w_wbyte     = i_byte_value;
                    w_wfail     = '0;
                    n_len       = LW'(1);
                    n_last_fail = '0;
                end
            end else begin
                if (i_first) begin
                    n_count = '0;
                    n_prog  = '0;
                end
                n_k = w_eff_prog;
            end
        end else if (i_cmd.step) begin
            if (!w_last) begin
                // follow the failure link
                n_k = r_fail_q;
            end else if (!r_is_text) begin
                w_we        = 1'b1;
                n_len       = r_len + LW'(1);
                n_last_fail = w_k_fin;
            end else if (w_k_fin == r_len) begin
                n_hit  = 1'b1;
                n_prog = r_last_fail;
                if (r_count != '1) begin
                    n_count = r_count + COUNT_BITS'(1);
                end
            end else begin
                n_prog = w_k_fin;
            end
        end
    end

    // memories: one write and one registered read each per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_store[w_waddr] <= w_wbyte;
            mem_fail[w_waddr]  <= w_wfail;
        end
        r_store_q <= mem_store[n_k[IW-1:0]];
        r_fail_q  <= mem_fail[w_km1[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_prog      <= '0;
            r_last_fail <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_prog      <= n_prog;
            r_last_fail <= n_last_fail;
            r_count     <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_hit <= n_hit;
        r_full <= n_full;
        if (i_cmd.accept) begin
            r_byte    <= i_byte_value;
            r_is_text <= i_action;
        end
        if (i_cmd.load_out) begin
            r_out_hit   <= r_hit;
            r_out_count <= kmpoc_pkg::OUT_COUNT_W'(r_count);
            r_out_full  <= r_full;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_here   = r_out_hit;
    assign o_match_count  = r_out_count;
    assign o_pattern_full = r_out_full;

endmodule

// ----- tb/kmp_occurrence_counter_core_tb.sv -----
// testbench for kmp_occurrence_counter_core: directed and random pattern/text streams
// checked item by item against an in-bench kmp predictor; depends on kmpoc_pkg and the core
module kmp_occurrence_counter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PATTERN_MAX = 64;
    localparam int COUNT_BITS  = 16;
    localparam logic [kmpoc_pkg::OUT_COUNT_W-1:0] COUNT_MAX =
        kmpoc_pkg::OUT_COUNT_W'((64'd1 << COUNT_BITS) - 1);
    localparam int IDLE_PCT    = 6;
    localparam int DRAIN_CYCLES = 200;
    localparam int COUNT_RUN   = 80;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef enum logic {
        ACT_PATTERN = 1'b0,
        ACT_TEXT    = 1'b1
    } t_action;

    typedef struct packed {
        logic                              hit;
        logic [kmpoc_pkg::OUT_COUNT_W-1:0] count;
        logic                              full;
    } t_match_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic                              i_action;
    logic [kmpoc_pkg::BYTE_W-1:0]      i_byte_value;
    logic                              i_first;
    logic                              o_valid;
    logic                              i_ready;
    logic                              o_match_here;
    logic [kmpoc_pkg::OUT_COUNT_W-1:0] o_match_count;
    logic                              o_pattern_full;

    // predictor state
    logic [kmpoc_pkg::BYTE_W-1:0]      pat_mem [PATTERN_MAX];
    logic [6:0]                        link_mem [PATTERN_MAX];
    int unsigned                       pat_len;
    int unsigned                       match_prog;
    logic [kmpoc_pkg::OUT_COUNT_W-1:0] occ_count;

    t_match_result expected_q[$];
    int unsigned   mismatches;
    int unsigned   items_sent;
    int unsigned   hits_seen;
    int unsigned   results_seen;
    longint        cycle_cnt;
    logic          quiet;

    kmp_occurrence_counter_core #(
        .PATTERN_MAX(PATTERN_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_byte_value  (i_byte_value),
        .i_first       (i_first),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_here  (o_match_here),
        .o_match_count (o_match_count),
        .o_pattern_full(o_pattern_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_match_result kmp_predict(t_action act,
                                                  logic [kmpoc_pkg::BYTE_W-1:0] c,
                                                  logic first);
        t_match_result r;
        int unsigned   k;
        int unsigned   pos;
        r = '0;
        if (act == ACT_PATTERN) begin
            if (first) begin
                pat_len    = 0;
                match_prog = 0;
            end
            if (pat_len >= PATTERN_MAX) begin
                r.full = 1'b1;
            end else begin
                pos = pat_len;
                k   = 0;
                if (pos > 0) begin
                    // extend the border of the prefix before the new byte
                    k = link_mem[pos-1];
                    while (k > 0 && pat_mem[k] != c)
                        k = link_mem[k-1];
                    if (pat_mem[k] == c)
                        k++;
                end
                pat_mem[pos]  = c;
                link_mem[pos] = 7'(k);
                pat_len       = pos + 1;
            end
        end else begin
            if (first) begin
                occ_count  = '0;
                match_prog = 0;
            end
            if (pat_len > 0) begin
                k = match_prog;
                while (k > 0 && k < PATTERN_MAX && pat_mem[k] != c)
                    k = link_mem[k-1];
                if (k < PATTERN_MAX && pat_mem[k] == c)
                    k++;
                if (k >= pat_len) begin
                    r.hit = 1'b1;
                    if (occ_count != COUNT_MAX)
                        occ_count++;
                    // overlapping occurrences: resume from the last border
                    k = link_mem[pat_len-1];
                end
                match_prog = k;
            end
        end
        r.count = occ_count;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint exp);
        mismatches++;
        $display("mismatch at cycle %0d result %0d: %s got %0d expected %0d",
                 cycle_cnt, results_seen, field, got, exp);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(t_action act, logic [kmpoc_pkg::BYTE_W-1:0] c, logic first);
        t_match_result r;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_byte_value <= c;
        i_first      <= first;
        do @(posedge i_clk); while (!o_ready);
        r = kmp_predict(act, c, first);
        expected_q.push_back(r);
        items_sent++;
        @(negedge i_clk);
    endtask

    // output side stalls
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_match_result exp;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, match_count", o_match_count, 0);
            end else begin
                exp = expected_q.pop_front();
                if (o_match_here !== exp.hit)
                    report_mismatch("match_here", o_match_here, exp.hit);
                if (o_match_count !== exp.count)
                    report_mismatch("match_count", o_match_count, exp.count);
                if (o_pattern_full !== exp.full)
                    report_mismatch("pattern_full", o_pattern_full, exp.full);
                if (exp.hit)
                    hits_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_empty_pattern();
        send_item(ACT_TEXT, 8'h00, 1'b1);
        send_item(ACT_TEXT, 8'hFF, 1'b0);
        send_item(ACT_TEXT, 8'h80, 1'b1);
    endtask

    task automatic test_overlap_and_append();
        send_item(ACT_PATTERN, 8'hA5, 1'b1);
        send_item(ACT_PATTERN, 8'h5A, 1'b0);
        send_item(ACT_PATTERN, 8'hA5, 1'b0);
        send_item(ACT_TEXT, 8'hA5, 1'b1);
        send_item(ACT_TEXT, 8'h5A, 1'b0);
        send_item(ACT_TEXT, 8'hA5, 1'b0);
        send_item(ACT_TEXT, 8'h5A, 1'b0);
        send_item(ACT_TEXT, 8'hA5, 1'b0);
        // grow the pattern while text progress is held
        send_item(ACT_PATTERN, 8'h5A, 1'b0);
        send_item(ACT_TEXT, 8'h5A, 1'b0);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b0);
        send_item(ACT_PATTERN, 8'hFF, 1'b1);
        send_item(ACT_TEXT, 8'hFF, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b0);
    endtask

    task automatic test_store_full();
        int i;
        for (i = 0; i < PATTERN_MAX; i++)
            send_item(ACT_PATTERN, 8'h00, i == 0);
        send_item(ACT_PATTERN, 8'hFF, 1'b0);
        send_item(ACT_PATTERN, 8'h00, 1'b0);
        for (i = 0; i < PATTERN_MAX + 4; i++)
            send_item(ACT_TEXT, 8'h00, i == 0);
        send_item(ACT_TEXT, 8'hFF, 1'b0);
        for (i = 0; i < PATTERN_MAX + 1; i++)
            send_item(ACT_TEXT, 8'h00, 1'b0);
    endtask

    // one hit per text item, then a miss and a text restart
    task automatic test_count_run();
        int i;
        send_item(ACT_PATTERN, 8'h3C, 1'b1);
        for (i = 0; i < COUNT_RUN; i++)
            send_item(ACT_TEXT, 8'h3C, i == 0);
        send_item(ACT_TEXT, 8'hC3, 1'b0);
        send_item(ACT_TEXT, 8'h3C, 1'b1);
    endtask

    task automatic test_random(int unsigned n_items);
        logic [kmpoc_pkg::BYTE_W-1:0] sym [3];
        logic [kmpoc_pkg::BYTE_W-1:0] pbuf [PATTERN_MAX];
        int unsigned                  plen_r;
        int unsigned                  tlen_r;
        int unsigned                  i;
        int unsigned                  start;
        int unsigned                  done;
        logic                         periodic;
        logic [kmpoc_pkg::BYTE_W-1:0] c;
        start = items_sent;
        done  = 0;
        while (done < n_items) begin
            quiet = (done > n_items / 3) && (done < n_items / 3 + 250);
            if ($urandom_range(99) < 80) begin
                for (i = 0; i < 3; i++)
                    sym[i] = 8'($urandom);
                plen_r = ($urandom_range(99) < 5) ? $urandom_range(7, PATTERN_MAX)
                                                  : $urandom_range(1, 6);
                for (i = 0; i < plen_r; i++) begin
                    pbuf[i] = sym[$urandom_range(1)];
                    send_item(ACT_PATTERN, pbuf[i], i == 0);
                end
                periodic = ($urandom_range(99) < 40);
                tlen_r   = $urandom_range(8, 40);
                for (i = 0; i < tlen_r; i++) begin
                    if ($urandom_range(99) < 4)
                        send_item(ACT_PATTERN, sym[$urandom_range(2)], 1'b0);
                    if (periodic && $urandom_range(99) < 90)
                        c = pbuf[i % plen_r];
                    else
                        c = sym[($urandom_range(99) < 10) ? 2 : $urandom_range(1)];
                    send_item(ACT_TEXT, c, (i == 0) && ($urandom_range(99) < 85));
                end
            end else begin
                send_item(t_action'($urandom_range(1)), 8'($urandom),
                          $urandom_range(99) < 30);
            end
            done = items_sent - start;
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = 1'b0;
        i_byte_value = '0;
        i_first      = 1'b0;
        i_ready      = 1'b0;
        quiet        = 1'b0;
        mismatches   = 0;
        items_sent   = 0;
        hits_seen    = 0;
        results_seen = 0;
        cycle_cnt    = 0;
        pat_len      = 0;
        match_prog   = 0;
        occ_count    = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pat_mem[i]  = '0;
            link_mem[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_pattern();
        test_overlap_and_append();
        test_store_full();
        test_count_run();
        test_random(1050);
        i_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items, checked %0d results with %0d occurrences", items_sent,
                 results_seen, hits_seen);
        $display("covered empty pattern, overlaps, appends, full store, long count runs, random");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
